// ----- rtl/core/km_pkg.sv -----
// Package for the k-means clustering engine: sizes, codes, and shared types.
// No dependencies.
`default_nettype none
package km_pkg;
    localparam int MAX_POINTS   = 1024;
    localparam int MAX_CLUSTERS = 8;
    localparam int MAX_DIMS     = 8;
    localparam int PW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_CLUSTERS);
    localparam int DW = $clog2(MAX_DIMS);

    typedef enum logic [1:0] {
        KIND_POINT    = 2'd0,
        KIND_CENTROID = 2'd1,
        KIND_RUN      = 2'd2,
        KIND_NONE     = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REG_CLUSTERS  = 3'd0,
        REG_DIMS      = 3'd1,
        REG_POINTS    = 3'd2,
        REG_MAX_ITER  = 3'd3,
        REG_THRESHOLD = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_FETCH, ST_DIST, ST_PICK, ST_ACC, ST_NEXT,
        ST_DIV, ST_DIVWAIT, ST_ITER_END, ST_OUT, ST_OUTWAIT
    } state_t;

    // Controller -> datapath.
    typedef struct packed {
        logic clear_acc;     // zero sums and counts (one entry per cycle, index c,j)
        logic dist_step;     // accumulate one squared term for (p,c,j)
        logic dist_start;    // clear distance for new centroid
        logic pick;          // compare distance with best
        logic assign_pt;     // write membership, bump counts, start sum walk
        logic acc_step;      // add one coordinate into sum
        logic div_start;     // start a divide for (c,j)
        logic out_load;      // read centroid (c,j) into the output
        logic [PW-1:0] p;
        logic [CW-1:0] c;
        logic [DW-1:0] j;
    } cmd_t;

    // Datapath -> controller.
    typedef struct packed {
        logic div_done;
        logic count_zero;
    } sts_t;
endpackage
`default_nettype wire

// ----- rtl/core/km_datapath.sv -----
// Datapath of the k-means engine: point, centroid and member memories, the
// distance and sum accumulators, and a serial divider. Uses km_pkg.
`default_nettype none
module km_datapath (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   ld_point,
    input  wire logic                   ld_cent,
    input  wire logic [km_pkg::PW-1:0]  ld_row,
    input  wire logic [km_pkg::DW-1:0]  ld_col,
    input  wire logic signed [15:0]     ld_val,
    input  wire km_pkg::cmd_t           cmd,
    output km_pkg::sts_t                sts,
    output logic                        changed,     // pulses with assign_pt
    output logic signed [15:0]          out_val
);
    import km_pkg::*;

    logic signed [15:0] point_mem [MAX_POINTS*MAX_DIMS];
    logic signed [15:0] cent_mem  [MAX_CLUSTERS*MAX_DIMS];
    logic [CW:0]        member_mem [MAX_POINTS];
    logic signed [26:0] sum_reg [MAX_CLUSTERS*MAX_DIMS];
    logic [10:0]        cnt_reg [MAX_CLUSTERS];
    logic [PW:0]        init_cnt_reg;   // members below this index were written

    logic [PW+DW-1:0] paddr;
    logic [CW+DW-1:0] caddr;
    assign paddr = ld_point ? {ld_row, ld_col} : {cmd.p, cmd.j};
    assign caddr = {cmd.c, cmd.j};

    // Registered memory reads.
    logic signed [15:0] prd_reg, crd_reg;
    always_ff @(posedge aclk) begin
        if (ld_point) point_mem[paddr] <= ld_val;
        prd_reg <= point_mem[paddr];
        crd_reg <= cent_mem[caddr];
    end

    // Distance: one squared term per cycle, product registered.
    // Read and square are each registered, so the valid flag passes through sq_vld1_reg and sq_vld_reg.
    logic signed [16:0] diff;
    logic [33:0] sq_reg;
    logic        sq_vld1_reg, sq_vld_reg;
    logic [36:0] dist_reg, best_reg;
    logic [CW-1:0] best_c_reg;
    assign diff = 17'(prd_reg) - 17'(crd_reg);
    always_ff @(posedge aclk) begin
        sq_reg      <= 34'(diff * diff);
        sq_vld1_reg <= cmd.dist_step;
        sq_vld_reg  <= sq_vld1_reg;
        if (cmd.dist_start) dist_reg <= '0;
        else if (sq_vld_reg) dist_reg <= dist_reg + 37'(sq_reg);
        if (cmd.pick) begin
            if (cmd.c == '0 || dist_reg < best_reg) begin
                best_reg   <= dist_reg;
                best_c_reg <= cmd.c;
            end
        end
    end

    // Membership, counts and sums.
    logic [CW:0] mem_rd;
    logic [CW:0] mrd_reg;
    logic signed [26:0] srd_reg, sdiv_reg;
    logic        acc_vld_reg;
    logic [CW-1:0] acc_c_reg;
    logic [DW-1:0] acc_j_reg;
    assign mem_rd = (11'(cmd.p) < init_cnt_reg) ? mrd_reg : (CW+1)'(MAX_CLUSTERS);
    assign changed = cmd.assign_pt && (mem_rd != {1'b0, best_c_reg});
    always_ff @(posedge aclk) begin
        mrd_reg  <= member_mem[cmd.p];
        srd_reg  <= sum_reg[{best_c_reg, cmd.j}];
        sdiv_reg <= sum_reg[caddr];
        if (cmd.assign_pt) member_mem[cmd.p] <= {1'b0, best_c_reg};
        acc_c_reg <= best_c_reg;
        acc_j_reg <= cmd.j;
        if (cmd.clear_acc) sum_reg[caddr] <= '0;
        else if (acc_vld_reg) sum_reg[{acc_c_reg, acc_j_reg}] <= srd_reg + 27'(prd_reg);
        if (cmd.clear_acc && cmd.j == '0) cnt_reg[cmd.c] <= '0;
        else if (cmd.assign_pt) cnt_reg[best_c_reg] <= cnt_reg[best_c_reg] + 11'd1;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_vld_reg  <= 1'b0;
            init_cnt_reg <= '0;
        end else begin
            acc_vld_reg <= cmd.acc_step;
            if (cmd.assign_pt && 11'(cmd.p) == init_cnt_reg)
                init_cnt_reg <= init_cnt_reg + 11'd1;
        end
    end

    // Restoring divider, one quotient bit per cycle, on magnitudes.
    // The sum is read at div_start and loaded in the cycle after, then 27 steps and a write-back.
    logic [26:0] dnum_reg, drem_reg;
    logic [10:0] dden_reg;
    logic [4:0]  dcnt_reg;
    logic        dneg_reg, dbusy_reg, dload_reg, div_done_reg;
    logic [CW+DW-1:0] daddr_reg;
    logic [27:0] trial;
    logic [26:0] q_signed;
    assign trial = {drem_reg, dnum_reg[26]} - 28'(dden_reg);
    assign q_signed = dneg_reg ? -dnum_reg : dnum_reg;
    assign sts = '{div_done: div_done_reg, count_zero: (cnt_reg[cmd.c] == '0)};
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg    <= 1'b0;
            dload_reg    <= 1'b0;
            div_done_reg <= 1'b0;
        end else begin
            div_done_reg <= 1'b0;
            dload_reg    <= cmd.div_start;
            if (cmd.div_start) begin
                dden_reg  <= cnt_reg[cmd.c];
                daddr_reg <= caddr;
            end else if (dload_reg) begin
                dbusy_reg <= 1'b1;
                dcnt_reg  <= 5'd27;
                dneg_reg  <= sdiv_reg[26];
                dnum_reg  <= sdiv_reg[26] ? 27'(-sdiv_reg) : sdiv_reg;
                drem_reg  <= '0;
            end else if (dbusy_reg) begin
                if (dcnt_reg == 5'd0) begin
                    dbusy_reg <= 1'b0;
                    div_done_reg <= 1'b1;
                end else begin
                    dcnt_reg <= dcnt_reg - 5'd1;
                    if (!trial[27]) begin
                        drem_reg <= trial[26:0];
                        dnum_reg <= {dnum_reg[25:0], 1'b1};
                    end else begin
                        drem_reg <= {drem_reg[25:0], dnum_reg[26]};
                        dnum_reg <= {dnum_reg[25:0], 1'b0};
                    end
                end
            end
        end
    end
    always_ff @(posedge aclk) begin
        if (ld_cent) cent_mem[{ld_row[CW-1:0], ld_col}] <= ld_val;
        else if (dbusy_reg && dcnt_reg == 5'd0) cent_mem[daddr_reg] <= q_signed[15:0];
    end
    assign out_val = crd_reg;
endmodule
`default_nettype wire

// ----- rtl/core/km_ctrl.sv -----
// Controller of the k-means engine: sequences iterations, point/centroid/
// coordinate walks, divides and result output. Uses km_pkg.
`default_nettype none
module km_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [3:0]            k_cfg,
    input  wire logic [3:0]            d_cfg,
    input  wire logic [10:0]           n_cfg,
    input  wire logic [7:0]            iter_cfg,
    input  wire logic [10:0]           thr_cfg,
    input  wire km_pkg::sts_t          sts,
    input  wire logic                  changed,
    input  wire logic                  out_free,
    output km_pkg::cmd_t               cmd,
    output logic                       busy,
    output logic                       out_push,
    output logic [7:0]                 iters,
    output logic [10:0]                changes,
    output logic                       out_last
);
    import km_pkg::*;

    state_t state_reg, state_next;
    logic [PW-1:0] p_reg, p_next;
    logic [CW-1:0] c_reg, c_next;
    logic [DW-1:0] j_reg, j_next;
    logic [1:0]    w_reg, w_next;    // pipeline drain counter
    logic [7:0]    it_reg, it_next;
    logic [10:0]   ch_reg, ch_next;
    logic [CW-1:0] kl;
    logic [DW-1:0] dl;
    logic [PW-1:0] nl;

    // Last index in use, counts saturated into 1..max.
    assign kl = (k_cfg == 4'd0) ? '0 : (k_cfg > 4'(MAX_CLUSTERS)) ? CW'(MAX_CLUSTERS-1)
              : CW'(k_cfg - 4'd1);
    assign dl = (d_cfg == 4'd0) ? '0 : (d_cfg > 4'(MAX_DIMS)) ? DW'(MAX_DIMS-1)
              : DW'(d_cfg - 4'd1);
    assign nl = (n_cfg == 11'd0) ? '0 : (n_cfg > 11'(MAX_POINTS)) ? PW'(MAX_POINTS-1)
              : PW'(n_cfg - 11'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            it_reg <= '0;
            ch_reg <= '0;
        end else begin
            state_reg <= state_next;
            it_reg <= it_next;
            ch_reg <= ch_next;
        end
        p_reg <= p_next;
        c_reg <= c_next;
        j_reg <= j_next;
        w_reg <= w_next;
    end

    always_comb begin
        state_next = state_reg;
        p_next = p_reg; c_next = c_reg; j_next = j_reg; w_next = w_reg;
        it_next = it_reg; ch_next = ch_reg;
        cmd = '0;
        cmd.p = p_reg; cmd.c = c_reg; cmd.j = j_reg;
        out_push = 1'b0;
        out_last = (c_reg == kl) && (j_reg == dl);
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    it_next = '0; ch_next = '0; c_next = '0; j_next = '0;
                    state_next = (iter_cfg == 8'd0) ? ST_OUT : ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                cmd.clear_acc = 1'b1;
                j_next = j_reg + 1'b1;
                if (j_reg == DW'(MAX_DIMS-1)) begin
                    c_next = c_reg + 1'b1;
                    if (c_reg == CW'(MAX_CLUSTERS-1)) begin
                        ch_next = '0; p_next = '0; c_next = '0; j_next = '0;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                cmd.dist_start = 1'b1;
                j_next = '0;
                state_next = ST_DIST;
            end
            ST_DIST: begin
                // issue reads j=0..dl; each read and square is registered before its term reaches the distance
                cmd.dist_step = 1'b1;
                j_next = j_reg + 1'b1;
                if (j_reg == dl) begin
                    w_next = 2'd2;
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                if (w_reg == 2'd0) begin
                    cmd.pick = 1'b1;
                    if (c_reg == kl) begin
                        j_next = '0;
                        state_next = ST_ACC;
                    end else begin
                        c_next = c_reg + 1'b1;
                        state_next = ST_FETCH;
                    end
                end else begin
                    w_next = w_reg - 2'd1;
                end
            end
            ST_ACC: begin
                if (j_reg == '0) begin
                    cmd.assign_pt = 1'b1;
                    if (changed) ch_next = ch_reg + 11'd1;
                end
                cmd.acc_step = 1'b1;
                j_next = j_reg + 1'b1;
                if (j_reg == dl) begin
                    w_next = 2'd1;
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (w_reg == 2'd0) begin
                    c_next = '0;
                    if (p_reg == nl) begin
                        j_next = '0;
                        state_next = ST_DIV;
                    end else begin
                        p_next = p_reg + 1'b1;
                        state_next = ST_FETCH;
                    end
                end else begin
                    w_next = w_reg - 2'd1;
                end
            end
            ST_DIV: begin
                if (sts.count_zero) begin
                    if (c_reg == kl) state_next = ST_ITER_END;
                    else c_next = c_reg + 1'b1;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIVWAIT;
                end
            end
            ST_DIVWAIT: begin
                if (sts.div_done) begin
                    state_next = ST_DIV;
                    j_next = j_reg + 1'b1;
                    if (j_reg == dl) begin
                        j_next = '0;
                        if (c_reg == kl) state_next = ST_ITER_END;
                        else c_next = c_reg + 1'b1;
                    end
                end
            end
            ST_ITER_END: begin
                it_next = it_reg + 8'd1;
                c_next = '0; j_next = '0;
                if (ch_reg <= thr_cfg || it_reg + 8'd1 == iter_cfg) state_next = ST_OUT;
                else state_next = ST_CLEAR;
            end
            ST_OUT: begin
                // read centroid (c,j); data lands next cycle
                cmd.out_load = 1'b1;
                state_next = ST_OUTWAIT;
            end
            ST_OUTWAIT: begin
                if (out_free) begin
                    out_push = 1'b1;
                    if (out_last) state_next = ST_IDLE;
                    else begin
                        state_next = ST_OUT;
                        j_next = j_reg + 1'b1;
                        if (j_reg == dl) begin
                            j_next = '0;
                            c_next = c_reg + 1'b1;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy    = (state_reg != ST_IDLE);
    assign iters   = it_reg;
    assign changes = ch_reg;
endmodule
`default_nettype wire

// ----- rtl/core/kmeans_lloyd_clustering.sv -----
// Lloyd k-means engine, top level: stream ports, config registers, output register.
// Load items are accepted whenever no run is in progress. A run computes distances with
// one squared term per cycle through a single multiplier, then a serial divide per
// centroid coordinate (an empty cluster is skipped without a divide), and the results
// are reported one at a time as the output register is free.
// No input is accepted during a run. Reset: synchronous active low; config to defaults.
`default_nettype none
module kmeans_lloyd_clustering (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [10:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // kind[1:0], row_index[11:2], coord_index[14:12],
                                        // coord_value[30:15], zero[31]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // cluster_id[2:0], out_coord_index[5:3],
                                        // centroid_value[21:6], iterations_done[29:22],
                                        // last_changes[40:30], zero[47:41]
    output logic             m_tlast    // is_last
);
    import km_pkg::*;

    logic [3:0]  k_reg, d_reg;
    logic [10:0] n_reg, thr_reg;
    logic [7:0]  it_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= 4'd8; d_reg <= 4'd8; n_reg <= 11'd1024; it_reg <= 8'd16; thr_reg <= '0;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_CLUSTERS:  k_reg   <= cfg_data[3:0];
                REG_DIMS:      d_reg   <= cfg_data[3:0];
                REG_POINTS:    n_reg   <= cfg_data;
                REG_MAX_ITER:  it_reg  <= cfg_data[7:0];
                REG_THRESHOLD: thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    kind_t kind;
    logic  busy, acc, out_push, out_last, changed;
    logic [7:0]  iters;
    logic [10:0] changes;
    logic signed [15:0] out_val;
    cmd_t cmd;
    sts_t sts;
    assign kind = kind_t'(s_tdata[1:0]);
    assign s_tready = !busy;
    assign acc = s_tvalid && s_tready;

    km_ctrl u_ctrl (
        .aclk, .aresetn,
        .start(acc && kind == KIND_RUN),
        .k_cfg(k_reg), .d_cfg(d_reg), .n_cfg(n_reg), .iter_cfg(it_reg), .thr_cfg(thr_reg),
        .sts, .changed, .out_free(!m_tvalid || m_tready),
        .cmd, .busy, .out_push, .iters, .changes, .out_last
    );

    km_datapath u_dp (
        .aclk, .aresetn,
        .ld_point(acc && kind == KIND_POINT),
        .ld_cent(acc && kind == KIND_CENTROID && s_tdata[11:2] < 10'(MAX_CLUSTERS)),
        .ld_row(s_tdata[11:2]), .ld_col(s_tdata[14:12]),
        .ld_val(s_tdata[30:15]),
        .cmd, .sts, .changed, .out_val
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) m_tvalid <= 1'b0;
        else if (out_push) m_tvalid <= 1'b1;
        else if (m_tready) m_tvalid <= 1'b0;
        if (out_push) begin
            m_tdata <= {7'd0, changes, iters, out_val, cmd.j, cmd.c};
            m_tlast <= out_last;
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_tready) else $error("input taken during run");
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_push |-> (!m_tvalid || m_tready)) else $error("output overwritten");
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_push && out_last) |=> !busy) else $error("run did not end on last");
endmodule
`default_nettype wire
